// ----- sv/dq_pkg.sv -----
// Package for the bounded double-ended queue.
// Holds sizes, operation and status codes, transaction structs and ring arithmetic.
// Used by every module of the block; depends on nothing.
package dq_pkg;

  // Store depth and the widths that follow from it.
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // Depth as a vector one bit wider than a ring index.
  localparam logic [IDX_W:0] DEPTH_EXT = (IDX_W + 1)'(DEPTH);
  // Depth as an occupancy value.
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  // Operation codes of a request; the remaining codes are ignored.
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_t;

  // Status codes of a result.
  typedef enum logic [1:0] {
    ST_POP   = 2'd0,
    ST_DUMP  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Request transaction.
  typedef struct packed {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] value;
  } dq_request_t;

  // Result transaction.
  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] item;
    logic                     last;
  } dq_result_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic dump_step;
    logic err_full;
    logic err_empty;
  } dq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       empty;
    logic       dump_end;
  } dq_stat_t;

  // Ring position base + offset, both below DEPTH, wrapped into the store.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                               input logic [IDX_W-1:0] offset);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= DEPTH_EXT) begin
      sum = sum - DEPTH_EXT;
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ----- sv/dq_ctrl.sv -----
// Controller state machine of the double-ended queue.
// Decodes the latched operation and sequences the datapath.
// Depends on dq_pkg.
module dq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  dq_pkg::dq_stat_t stat,
  output dq_pkg::dq_cmd_t  cmd
);

  dq_pkg::state_t state;
  dq_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      dq_pkg::S_IDLE: begin
        if (start) begin
          state_next = dq_pkg::S_EXEC;
        end
      end
      dq_pkg::S_EXEC: begin
        state_next = dq_pkg::S_IDLE;
        if (stat.op == dq_pkg::OP_DUMP && !stat.empty && !stat.dump_end) begin
          state_next = dq_pkg::S_DUMP;
        end
      end
      dq_pkg::S_DUMP: begin
        if (stat.dump_end) begin
          state_next = dq_pkg::S_IDLE;
        end
      end
      default: state_next = dq_pkg::S_IDLE;
    endcase
  end

  // Output logic: commands to the datapath.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      dq_pkg::S_IDLE: begin
        busy         = 1'b0;
        cmd.load_req = start;
      end
      dq_pkg::S_EXEC: begin
        unique case (stat.op)
          dq_pkg::OP_PUSH_FRONT: begin
            cmd.err_full   = stat.full;
            cmd.push_front = !stat.full;
          end
          dq_pkg::OP_PUSH_BACK: begin
            cmd.err_full  = stat.full;
            cmd.push_back = !stat.full;
          end
          dq_pkg::OP_POP_FRONT: begin
            cmd.err_empty = stat.empty;
            cmd.pop_front = !stat.empty;
          end
          dq_pkg::OP_POP_BACK: begin
            cmd.err_empty = stat.empty;
            cmd.pop_back  = !stat.empty;
          end
          dq_pkg::OP_DUMP: begin
            cmd.dump_step = !stat.empty;
          end
          default: cmd = '0;
        endcase
      end
      dq_pkg::S_DUMP: begin
        cmd.dump_step = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- sv/dq_datapath.sv -----
// Datapath of the double-ended queue: ring store, front pointer, occupancy,
// dump counter and the result register. Depends on dq_pkg.
module dq_datapath (
  input  logic                clk,
  input  logic                rst,
  input  dq_pkg::dq_request_t request,
  input  dq_pkg::dq_cmd_t     cmd,
  output dq_pkg::dq_stat_t    stat,
  output dq_pkg::dq_result_t  result,
  output logic                result_valid
);

  logic [dq_pkg::DATA_W-1:0] mem [dq_pkg::DEPTH];

  logic [2:0]                op_q;
  logic [dq_pkg::DATA_W-1:0] value_q;
  logic [dq_pkg::IDX_W-1:0]  front_idx;
  logic [dq_pkg::CNT_W-1:0]  occupancy;
  logic [dq_pkg::IDX_W-1:0]  dump_idx;

  logic [dq_pkg::DATA_W-1:0] item_q;
  dq_pkg::status_t           status_q;
  logic                      last_q;

  logic [dq_pkg::IDX_W-1:0]  front_dec;
  logic [dq_pkg::IDX_W-1:0]  front_inc;
  logic [dq_pkg::IDX_W-1:0]  back_pos;
  logic [dq_pkg::CNT_W-1:0]  occ_m1;
  logic [dq_pkg::CNT_W-1:0]  dump_cnt;
  logic [dq_pkg::IDX_W-1:0]  waddr;
  logic [dq_pkg::IDX_W-1:0]  raddr;
  logic                      do_write;
  logic                      do_read;

  // Ring positions derived from the pointer and the count.
  always_comb begin
    front_dec = dq_pkg::ring_add(front_idx, dq_pkg::IDX_W'(dq_pkg::DEPTH - 1));
    front_inc = dq_pkg::ring_add(front_idx, dq_pkg::IDX_W'(1));
    back_pos  = dq_pkg::ring_add(front_idx, occupancy[dq_pkg::IDX_W-1:0]);
    occ_m1    = occupancy - dq_pkg::CNT_W'(1);
    dump_cnt  = dq_pkg::CNT_W'(dump_idx) + dq_pkg::CNT_W'(1);
  end

  // Status toward the controller.
  always_comb begin
    stat.op       = op_q;
    stat.full     = (occupancy == dq_pkg::DEPTH_CNT);
    stat.empty    = (occupancy == '0);
    stat.dump_end = (dump_cnt == occupancy);
  end

  // Store addresses for this cycle.
  always_comb begin
    do_write = cmd.push_front | cmd.push_back;
    do_read  = cmd.pop_front | cmd.pop_back | cmd.dump_step;
    waddr    = cmd.push_front ? front_dec : back_pos;
    priority if (cmd.pop_front) begin
      raddr = front_idx;
    end else if (cmd.pop_back) begin
      raddr = dq_pkg::ring_add(front_idx, occ_m1[dq_pkg::IDX_W-1:0]);
    end else begin
      raddr = dq_pkg::ring_add(front_idx, dump_idx);
    end
  end

  // Request latch; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_q    <= request.op;
      value_q <= request.value;
    end
  end

  // Ring store write port.
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[waddr] <= value_q;
    end
  end

  // Ring store read port, registered straight into the result item.
  always_ff @(posedge clk) begin
    if (do_read) begin
      item_q <= mem[raddr];
    end else if (cmd.err_full || cmd.err_empty) begin
      item_q <= '0;
    end
  end

  // Front pointer, occupancy and dump counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_idx <= '0;
      occupancy <= '0;
      dump_idx  <= '0;
    end else begin
      if (cmd.push_front) begin
        front_idx <= front_dec;
      end else if (cmd.pop_front) begin
        front_idx <= front_inc;
      end
      if (cmd.push_front || cmd.push_back) begin
        occupancy <= occupancy + dq_pkg::CNT_W'(1);
      end else if (cmd.pop_front || cmd.pop_back) begin
        occupancy <= occ_m1;
      end
      if (cmd.load_req) begin
        dump_idx <= '0;
      end else if (cmd.dump_step) begin
        dump_idx <= dump_idx + dq_pkg::IDX_W'(1);
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= do_read | cmd.err_full | cmd.err_empty;
    end
  end

  // Result status and last flag.
  always_ff @(posedge clk) begin
    priority if (cmd.dump_step) begin
      status_q <= dq_pkg::ST_DUMP;
      last_q   <= stat.dump_end;
    end else if (cmd.err_full) begin
      status_q <= dq_pkg::ST_FULL;
      last_q   <= 1'b1;
    end else if (cmd.err_empty) begin
      status_q <= dq_pkg::ST_EMPTY;
      last_q   <= 1'b1;
    end else if (cmd.pop_front || cmd.pop_back) begin
      status_q <= dq_pkg::ST_POP;
      last_q   <= 1'b1;
    end
  end

  // Result transaction.
  always_comb begin
    result.status = status_q;
    result.item   = item_q;
    result.last   = last_q;
  end

endmodule

// ----- sv/double_ended_queue.sv -----
// Bounded double-ended queue of signed 32-bit values in a ring store.
// Usage:
//   A request transaction (op, value) is taken at a rising edge where start
//   is high and busy is low. Ops: push front, push back, pop front, pop back,
//   dump contents. Results come on result with result_valid high for one
//   cycle each; the receiver cannot stall, so every result must be taken.
// Sequencing:
//   A push or pop holds busy while it executes; its pop or error result is
//   registered as the execute state ends. A dump reads one element per
//   cycle from the single store read port, so its results arrive on
//   consecutive cycles and the block stays busy until the last is read.
//   The last result of every request that gives results has last set; a
//   push that succeeds gives none. A dump of an empty queue gives no result.
//   A new request may be accepted while the final result is on the outputs.
// Reset:
//   rst (synchronous, active high) empties the queue and clears the front
//   pointer; no clearing pass is needed, since only occupied entries are read.
// Depends on dq_pkg, dq_ctrl and dq_datapath.
module double_ended_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  dq_pkg::dq_request_t request,
  output dq_pkg::dq_result_t  result,
  output logic                result_valid
);

  dq_pkg::dq_cmd_t  cmd;
  dq_pkg::dq_stat_t stat;

  // Controller.
  dq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Datapath.
  dq_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// ----- sv/dq_checker.sv -----
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on dq_pkg and double_ended_queue.
module dq_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input dq_pkg::dq_result_t  result,
  input logic                result_valid
);

  // An accepted transaction keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low right after an accepted transaction");

  // Error results carry a zero item.
  a_error_item_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == dq_pkg::ST_EMPTY ||
                     result.status == dq_pkg::ST_FULL) |-> result.item == '0)
    else $error("error result with nonzero item");

  // Only dump results may be followed by more results of the same request.
  a_single_result_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != dq_pkg::ST_DUMP |-> result.last)
    else $error("pop or error result without last");

  // A dump result that is not the last is followed at once by another one.
  a_dump_continues: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |=>
      result_valid && result.status == dq_pkg::ST_DUMP)
    else $error("dump sequence broken before its last element");

  // A dump in progress keeps the block busy.
  a_dump_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("block idle while a dump is still running");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result       (result),
  .result_valid (result_valid)
);
